/* hdl/uvs_pkg.sv */
package uvs_pkg;

   localparam int MaxSegments = 255;
   localparam int AngleIterations = 16;
   localparam int SegW = 8;
   localparam int AngW = 32;
   localparam int CordW = 34;
   localparam int DivN = 40;
   localparam int Depth = DivN + AngleIterations;

   localparam logic [CordW-1:0] CordicK = CordW'(652032874);
   localparam logic [AngW-1:0] Quarter = 32'h4000_0000;

   localparam logic ActVertex = 1'b0;
   localparam logic ActCell = 1'b1;

   localparam logic CsrSegments = 1'b0;
   localparam logic CsrRadius = 1'b1;

   function automatic logic signed [AngW:0] atan_entry(input int i);
      logic signed [AngW:0] v;
      begin
         v = '0;
         case (i)
            0: v = 33'sd536870912;
            1: v = 33'sd316933406;
            2: v = 33'sd167458907;
            3: v = 33'sd85004756;
            4: v = 33'sd42667331;
            5: v = 33'sd21354465;
            6: v = 33'sd10679838;
            7: v = 33'sd5340245;
            8: v = 33'sd2670163;
            9: v = 33'sd1335087;
            10: v = 33'sd667544;
            11: v = 33'sd333772;
            12: v = 33'sd166886;
            13: v = 33'sd83443;
            14: v = 33'sd41722;
            15: v = 33'sd20861;
            16: v = 33'sd10430;
            17: v = 33'sd5215;
            18: v = 33'sd2608;
            19: v = 33'sd1304;
            20: v = 33'sd652;
            21: v = 33'sd326;
            22: v = 33'sd163;
            23: v = 33'sd81;
            default: v = '0;
         endcase
         return v;
      end
   endfunction

   typedef struct packed {
      logic signed [CordW-1:0] x;
      logic signed [CordW-1:0] y;
      logic signed [AngW:0] z;
   } rot_type;

   // one request in flight along the chain
   typedef struct packed {
      logic vld;
      logic act;
      logic [SegW-1:0] row;
      logic [SegW-1:0] col;
      logic [SegW-1:0] seg;
      logic [15:0] rad;
      logic ok;
      logic neg_st;
      logic neg_se;
   } tok_type;

endpackage

/* hdl/uvs_div.sv */
// restoring divider cell: one quotient bit per cycle, passed to the next cell
module uvs_div (
   input  logic clock,
   input  logic [39:0] num_in_i,
   input  logic [7:0] den_i,
   input  logic [39:0] quo_i,
   input  logic [8:0] rem_i,
   output logic [39:0] num_o,
   output logic [7:0] den_o,
   output logic [39:0] quo_o,
   output logic [8:0] rem_o
);
   logic [9:0] trial;
   logic [8:0] rem_in;
   logic [39:0] quo_in;
   logic [39:0] num_ff, quo_ff;
   logic [7:0] den_ff;
   logic [8:0] rem_ff;

   always_comb begin
      trial = {rem_i, num_in_i[39]};
      if (trial >= {2'b0, den_i}) begin
         rem_in = 9'(trial - {2'b0, den_i});
         quo_in = {quo_i[38:0], 1'b1};
      end else begin
         rem_in = trial[8:0];
         quo_in = {quo_i[38:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= {num_in_i[38:0], 1'b0};
      den_ff <= den_i;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign num_o = num_ff;
   assign den_o = den_ff;
   assign quo_o = quo_ff;
   assign rem_o = rem_ff;
endmodule

/* hdl/uvs_cordic.sv */
// one cordic micro-rotation stage
module uvs_cordic (
   input  logic clock,
   input  logic [4:0] shift_i,
   input  uvs_pkg::rot_type rot_i,
   output uvs_pkg::rot_type rot_o
);
   import uvs_pkg::*;
   rot_type rot_in, rot_ff;
   logic signed [AngW:0] ang;

   always_comb begin
      ang = atan_entry(int'(shift_i));
      rot_in = rot_i;
      if (!rot_i.z[AngW]) begin
         rot_in.x = rot_i.x - (rot_i.y >>> shift_i);
         rot_in.y = rot_i.y + (rot_i.x >>> shift_i);
         rot_in.z = rot_i.z - ang;
      end else begin
         rot_in.x = rot_i.x + (rot_i.y >>> shift_i);
         rot_in.y = rot_i.y - (rot_i.x >>> shift_i);
         rot_in.z = rot_i.z + ang;
      end
   end

   always_ff @(posedge clock) rot_ff <= rot_in;
   assign rot_o = rot_ff;
endmodule

/* hdl/uv_sphere_tessellator.sv */
// channel   | ports                          | direction
// ----------+--------------------------------+----------
// request   | start, busy, req_action/row/col | in, busy out
// result    | rsp_valid, rsp_* fields, rsp_last | out
// csr       | csr_we, csr_index, csr_wdata    | in
//
// a request enters a chain of cells every cycle busy is low; busy is low except on the
// cycle after a cell request that makes two triangles (second result slot).
// registers from request to result: input register,
// 40 divider cells, angle fold, 16 cordic cells, 3 product stages, output register.
// reset is synchronous, clears valid bits and sets the csr registers to defaults.
// the receiver cannot stall; each result shows for one cycle with rsp_valid.
module uv_sphere_tessellator (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic req_action,
   input  logic [7:0] req_row,
   input  logic [7:0] req_col,
   input  logic csr_we,
   input  logic csr_index,
   input  logic [15:0] csr_wdata,
   output logic rsp_valid,
   output logic signed [16:0] rsp_pos_x,
   output logic signed [16:0] rsp_pos_y,
   output logic signed [16:0] rsp_pos_z,
   output logic signed [15:0] rsp_norm_x,
   output logic signed [15:0] rsp_norm_y,
   output logic signed [15:0] rsp_norm_z,
   output logic [16:0] rsp_tex_s,
   output logic [16:0] rsp_tex_t,
   output logic [15:0] rsp_tri_a,
   output logic [15:0] rsp_tri_b,
   output logic [15:0] rsp_tri_c,
   output logic rsp_last
);
   import uvs_pkg::*;

   logic [7:0] seg_ff;
   logic [15:0] rad_ff;
   logic [7:0] seg_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff <= 8'd16;
         rad_ff <= 16'd256;
      end else if (csr_we) begin
         unique case (csr_index)
            CsrSegments: seg_ff <= csr_wdata[7:0];
            CsrRadius: rad_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      seg_eff = (seg_ff == 8'd0) ? 8'd1 : seg_ff;
      if (int'(seg_eff) > MaxSegments) seg_eff = 8'(MaxSegments);
   end

   // second triangle slot: hold the input for one cycle
   logic hold_ff, accept;
   logic cell_two;
   assign accept = start && !busy;
   assign busy = hold_ff;
   assign cell_two = req_action == ActCell && req_row != 8'd0
                     && {1'b0, req_row} != {1'b0, seg_eff} - 9'd1;
   always_ff @(posedge clock) begin
      if (reset) hold_ff <= 1'b0;
      else hold_ff <= accept && cell_two && req_row < seg_eff && req_col < seg_eff;
   end

   // two dividers run side by side: stack (row*2^31+S/2)/S, sector (col*2^32+S/2)/S
   // the 40-bit numerators give quotients whose top bits also yield tex values
   tok_type tok [Depth+1];
   logic [39:0] nA [DivN+1]; logic [39:0] qA [DivN+1]; logic [8:0] rA [DivN+1];
   logic [39:0] nB [DivN+1]; logic [39:0] qB [DivN+1]; logic [8:0] rB [DivN+1];
   logic [7:0] dA [DivN+1]; logic [7:0] dB [DivN+1];
   tok_type t0;

   always_comb begin
      t0 = '0;
      t0.vld = accept;
      t0.act = req_action;
      t0.row = req_row;
      t0.col = req_col;
      t0.seg = seg_eff;
      t0.rad = rad_ff;
      if (req_action == ActVertex) t0.ok = req_row <= seg_eff && req_col <= seg_eff;
      else t0.ok = req_row < seg_eff && req_col < seg_eff;
   end

   always_ff @(posedge clock) begin
      if (reset) tok[0] <= '0;
      else tok[0] <= t0;
      nA[0] <= ({32'b0, req_row} << 31) + 40'(seg_eff >> 1);
      nB[0] <= ({32'b0, req_col} << 32) + 40'(seg_eff >> 1);
   end
   assign qA[0] = '0; assign rA[0] = '0; assign dA[0] = tok[0].seg;
   assign qB[0] = '0; assign rB[0] = '0; assign dB[0] = tok[0].seg;

   for (genvar g = 0; g < DivN; g++) begin : g_div
      uvs_div u_a (.clock, .num_in_i(nA[g]), .den_i(dA[g]), .quo_i(qA[g]), .rem_i(rA[g]),
                   .num_o(nA[g+1]), .den_o(dA[g+1]), .quo_o(qA[g+1]), .rem_o(rA[g+1]));
      uvs_div u_b (.clock, .num_in_i(nB[g]), .den_i(dB[g]), .quo_i(qB[g]), .rem_i(rB[g]),
                   .num_o(nB[g+1]), .den_o(dB[g+1]), .quo_o(qB[g+1]), .rem_o(rB[g+1]));
      always_ff @(posedge clock) begin
         if (reset) tok[g+1] <= '0;
         else tok[g+1] <= tok[g];
      end
   end

   // angle folding into [-1/4,1/4] turn
   logic [31:0] st_ang, se_ang;
   logic [16:0] tex_s0, tex_t0;
   rot_type rs [AngleIterations+1];
   rot_type rc [AngleIterations+1];
   rot_type rs0, rc0;
   tok_type tk;

   function automatic rot_type fold(input logic [31:0] a, output logic neg);
      rot_type r;
      logic signed [AngW:0] z;
      begin
         z = {a[31], a};
         neg = 1'b0;
         if (z > $signed({1'b0, Quarter})) begin
            z = z - 33'sh0_8000_0000; neg = 1'b1;
         end else if (z < -$signed({1'b0, Quarter})) begin
            z = z + 33'sh0_8000_0000; neg = 1'b1;
         end
         r.x = CordicK;
         r.y = '0;
         r.z = z;
         return r;
      end
   endfunction

   always_comb begin
      st_ang = 32'(Quarter - qA[DivN][31:0]);
      se_ang = qB[DivN][31:0];
      tex_t0 = 17'((qA[DivN] + 40'd16384) >> 15);
      tex_s0 = 17'((qB[DivN] + 40'd32768) >> 16);
      tk = tok[DivN];
      rs0 = fold(st_ang, tk.neg_st);
      rc0 = fold(se_ang, tk.neg_se);
   end

   // tex values travel with the token in a side pipe
   logic [16:0] ts_p [AngleIterations+1];
   logic [16:0] tt_p [AngleIterations+1];
   tok_type tc [AngleIterations+1];
   always_ff @(posedge clock) begin
      rs[0] <= rs0; rc[0] <= rc0;
      ts_p[0] <= tex_s0; tt_p[0] <= tex_t0;
      if (reset) tc[0] <= '0;
      else tc[0] <= tk;
   end

   for (genvar g = 0; g < AngleIterations; g++) begin : g_cor
      uvs_cordic u_s (.clock, .shift_i(5'(g)), .rot_i(rs[g]), .rot_o(rs[g+1]));
      uvs_cordic u_c (.clock, .shift_i(5'(g)), .rot_i(rc[g]), .rot_o(rc[g+1]));
      always_ff @(posedge clock) begin
         ts_p[g+1] <= ts_p[g];
         tt_p[g+1] <= tt_p[g];
         if (reset) tc[g+1] <= '0;
         else tc[g+1] <= tc[g];
      end
   end

   // product stages
   logic signed [CordW-1:0] cs_v, ss_v, cc_v, sc_v;
   tok_type tp;
   always_comb begin
      tp = tc[AngleIterations];
      cs_v = tp.neg_st ? -rs[AngleIterations].x : rs[AngleIterations].x;
      ss_v = tp.neg_st ? -rs[AngleIterations].y : rs[AngleIterations].y;
      cc_v = tp.neg_se ? -rc[AngleIterations].x : rc[AngleIterations].x;
      sc_v = tp.neg_se ? -rc[AngleIterations].y : rc[AngleIterations].y;
   end
   logic signed [CordW-1:0] cs1, ss1, cc1, sc1, cc2, sc2;
   logic signed [50:0] xy_p, z_p;
   logic signed [67:0] nx_p, ny_p;
   logic signed [20:0] nz2;
   logic signed [56:0] px_p, py_p;
   logic signed [20:0] pz3, nx3, ny3, nz3, px3, py3;
   logic [16:0] ts1, tt1, ts2, tt2, ts3, tt3;
   tok_type k1, k2, k3;
   always_ff @(posedge clock) begin
      cs1 <= cs_v; ss1 <= ss_v; cc1 <= cc_v; sc1 <= sc_v;
      ts1 <= ts_p[AngleIterations]; tt1 <= tt_p[AngleIterations];
      if (reset) k1 <= '0; else k1 <= tc[AngleIterations];
      xy_p <= $signed({1'b0, k1.rad}) * cs1 + 51'sd536870912;
      z_p <= $signed({1'b0, k1.rad}) * ss1 + 51'sd536870912;
      nx_p <= cs1 * cc1 + 68'sh2000_0000_0000;
      ny_p <= cs1 * sc1 + 68'sh2000_0000_0000;
      nz2 <= 21'((ss1 + 34'sd32768) >>> 16);
      cc2 <= cc1; sc2 <= sc1;
      ts2 <= ts1; tt2 <= tt1;
      if (reset) k2 <= '0; else k2 <= k1;
      px_p <= 57'(23'(xy_p >>> 30)) * 57'(cc2) + 57'sd536870912;
      py_p <= 57'(23'(xy_p >>> 30)) * 57'(sc2) + 57'sd536870912;
      pz3 <= 21'(z_p >>> 30);
      nx3 <= 21'(nx_p >>> 46);
      ny3 <= 21'(ny_p >>> 46);
      nz3 <= nz2;
      ts3 <= ts2; tt3 <= tt2;
      if (reset) k3 <= '0; else k3 <= k2;
   end
   always_comb begin
      px3 = 21'(px_p >>> 30);
      py3 = 21'(py_p >>> 30);
   end

   function automatic logic signed [16:0] sat17(input logic signed [20:0] v);
      if (v > 21'sd65535) return 17'sd65535;
      if (v < -21'sd65535) return -17'sd65535;
      return v[16:0];
   endfunction
   function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
      if (v > 21'sd16384) return 16'sd16384;
      if (v < -21'sd16384) return -16'sd16384;
      return v[15:0];
   endfunction

   // output slot: vertex, or one/two triangles, the second sent in its own result slot
   logic [15:0] a_v, w_v;
   logic top, bot, second_ff;
   logic [15:0] sa_ff, sb_ff;
   always_comb begin
      w_v = 16'(k3.seg) + 16'd1;
      a_v = 16'(16'(k3.row) * w_v + 16'(k3.col));
      top = k3.row != 8'd0;
      bot = {1'b0, k3.row} != {1'b0, k3.seg} - 9'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0; second_ff <= 1'b0;
      end else begin
         second_ff <= 1'b0;
         rsp_valid <= 1'b0;
         rsp_pos_x <= '0; rsp_pos_y <= '0; rsp_pos_z <= '0;
         rsp_norm_x <= '0; rsp_norm_y <= '0; rsp_norm_z <= '0;
         rsp_tex_s <= '0; rsp_tex_t <= '0;
         rsp_tri_a <= '0; rsp_tri_b <= '0; rsp_tri_c <= '0;
         rsp_last <= 1'b1;
         if (second_ff) begin
            rsp_valid <= 1'b1;
            rsp_tri_a <= sa_ff + 16'd1;
            rsp_tri_b <= sb_ff;
            rsp_tri_c <= sb_ff + 16'd1;
         end else if (k3.vld && k3.ok) begin
            if (k3.act == ActVertex) begin
               rsp_valid <= 1'b1;
               rsp_pos_x <= sat17(px3); rsp_pos_y <= sat17(py3);
               rsp_pos_z <= sat17(pz3);
               rsp_norm_x <= sat16(nx3); rsp_norm_y <= sat16(ny3);
               rsp_norm_z <= sat16(nz3);
               rsp_tex_s <= ts3; rsp_tex_t <= tt3;
            end else if (top) begin
               rsp_valid <= 1'b1;
               rsp_tri_a <= a_v;
               rsp_tri_b <= a_v + w_v;
               rsp_tri_c <= a_v + 16'd1;
               rsp_last <= !bot;
               second_ff <= bot;
            end else if (bot) begin
               rsp_valid <= 1'b1;
               rsp_tri_a <= a_v + 16'd1;
               rsp_tri_b <= a_v + w_v;
               rsp_tri_c <= a_v + w_v + 16'd1;
            end
         end
         sa_ff <= a_v;
         sb_ff <= a_v + w_v;
      end
   end
endmodule

/* tb/uv_sphere_tessellator_test.sv */
`timescale 1ns / 100ps

module uv_sphere_tessellator_test;
   import uvs_pkg::*;

   // fixed-point constants of the angle datapath
   localparam longint AngHalf = 64'sd2147483648;
   localparam longint AngQuarter = 64'sd1073741824;
   localparam longint CordicGain = 64'sd652032874;
   localparam int IdleLimit = 3000;
   localparam int DrainCycles = 80;

   // arctangent steps in binary angle units, 2^32 to a full turn
   localparam longint AtanStep [0:23] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81
   };

   typedef struct {
      logic signed [16:0] pos_x, pos_y, pos_z;
      logic signed [15:0] norm_x, norm_y, norm_z;
      logic [16:0] tex_s, tex_t;
      logic [15:0] tri_a, tri_b, tri_c;
      logic last;
   } mesh_rsp_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic req_action;
   logic [7:0] req_row;
   logic [7:0] req_col;
   logic csr_we;
   logic csr_index;
   logic [15:0] csr_wdata;
   logic rsp_valid;
   logic signed [16:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [15:0] rsp_norm_x, rsp_norm_y, rsp_norm_z;
   logic [16:0] rsp_tex_s, rsp_tex_t;
   logic [15:0] rsp_tri_a, rsp_tri_b, rsp_tri_c;
   logic rsp_last;

   // shadow copy of the two registers
   logic [7:0] seg_shadow;
   logic [15:0] radius_shadow;

   mesh_rsp_type mesh_queue [$];
   int errors;
   int n_requests;
   int n_vertices;
   int n_triangles;
   int n_settings;
   int idle_cycles;

   uv_sphere_tessellator u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_row(req_row), .req_col(req_col),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid),
      .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y), .rsp_pos_z(rsp_pos_z),
      .rsp_norm_x(rsp_norm_x), .rsp_norm_y(rsp_norm_y), .rsp_norm_z(rsp_norm_z),
      .rsp_tex_s(rsp_tex_s), .rsp_tex_t(rsp_tex_t),
      .rsp_tri_a(rsp_tri_a), .rsp_tri_b(rsp_tri_b), .rsp_tri_c(rsp_tri_c),
      .rsp_last(rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // effective segment count, zero acts as one
   function automatic longint eff_segments();
      return (seg_shadow == 8'd0) ? 64'd1 : longint'(seg_shadow);
   endfunction

   function automatic longint clip(input longint v, input longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // rotation cordic: binary angle in, cos and sin out in q1.30
   function automatic void sin_cos(input longint ang, output longint c, output longint s);
      longint z, x, y, nx;
      bit flip;
      z = ang;
      x = CordicGain;
      y = 0;
      flip = 1'b0;
      if (z >= AngHalf) z -= 2 * AngHalf;
      if (z > AngQuarter) begin
         z -= AngHalf;
         flip = 1'b1;
      end else if (z < -AngQuarter) begin
         z += AngHalf;
         flip = 1'b1;
      end
      for (int i = 0; i < AngleIterations && i < 24; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= AtanStep[i];
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += AtanStep[i];
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = x;
      s = y;
   endfunction

   // push the results that one accepted request must produce
   function automatic void predict_mesh(input logic act, input logic [7:0] row,
                                        input logic [7:0] col);
      longint seg, r, c, st_ang, se_ang, cs, ss, cc, sc, xy, rad, w, a, b;
      mesh_rsp_type m;
      seg = eff_segments();
      r = longint'(row);
      c = longint'(col);
      rad = longint'(radius_shadow);
      m = '{default: '0};
      if (act == ActVertex) begin
         if (r > seg || c > seg) return;
         st_ang = (AngQuarter - (((r << 31) + seg / 2) / seg)) & 64'hFFFF_FFFF;
         se_ang = (((c << 32) + seg / 2) / seg) & 64'hFFFF_FFFF;
         sin_cos(st_ang, cs, ss);
         sin_cos(se_ang, cc, sc);
         xy = (rad * cs + (64'sd1 << 29)) >>> 30;
         m.pos_x = 17'(clip((xy * cc + (64'sd1 << 29)) >>> 30, 65535));
         m.pos_y = 17'(clip((xy * sc + (64'sd1 << 29)) >>> 30, 65535));
         m.pos_z = 17'(clip((rad * ss + (64'sd1 << 29)) >>> 30, 65535));
         m.norm_x = 16'(clip((cs * cc + (64'sd1 << 45)) >>> 46, 16384));
         m.norm_y = 16'(clip((cs * sc + (64'sd1 << 45)) >>> 46, 16384));
         m.norm_z = 16'(clip((ss + (64'sd1 << 15)) >>> 16, 16384));
         m.tex_s = 17'(((c << 16) + seg / 2) / seg);
         m.tex_t = 17'(((r << 16) + seg / 2) / seg);
         m.last = 1'b1;
         mesh_queue.push_back(m);
      end else begin
         if (r >= seg || c >= seg) return;
         w = seg + 1;
         a = r * w + c;
         b = a + w;
         // top triangle skipped on the first row
         if (r != 0) begin
            m.tri_a = 16'(a);
            m.tri_b = 16'(b);
            m.tri_c = 16'(a + 1);
            m.last = (r == seg - 1);
            mesh_queue.push_back(m);
         end
         // bottom triangle skipped on the last row
         if (r != seg - 1) begin
            m.tri_a = 16'(a + 1);
            m.tri_b = 16'(b);
            m.tri_c = 16'(b + 1);
            m.last = 1'b1;
            mesh_queue.push_back(m);
         end
      end
   endfunction

   // send one request; start stays high on return so bursts run back to back
   task automatic send_request(input logic act, input logic [7:0] row,
                               input logic [7:0] col);
      start <= 1'b1;
      req_action <= act;
      req_row <= row;
      req_col <= col;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      predict_mesh(act, row, col);
      n_requests++;
   endtask

   task automatic pause_sender(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // idle until every expected result is in, then let the chain empty
   task automatic drain_mesh();
      start <= 1'b0;
      while (mesh_queue.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [15:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CsrSegments) seg_shadow = data[7:0];
      else radius_shadow = data;
   endtask

   task automatic set_sphere(input logic [7:0] seg, input logic [15:0] rad);
      drain_mesh();
      write_csr(CsrSegments, {8'd0, seg});
      write_csr(CsrRadius, rad);
      n_settings++;
   endtask

   // reset values, then corners, an inner point and out-of-range requests on the default grid
   task automatic test_default_grid();
      send_request(ActVertex, 8'd0, 8'd0);
      send_request(ActVertex, 8'd16, 8'd16);
      send_request(ActVertex, 8'd8, 8'd4);
      send_request(ActVertex, 8'd17, 8'd0);    // row past the grid
      send_request(ActVertex, 8'd0, 8'd17);    // col past the grid
      send_request(ActCell, 8'd0, 8'd0);       // first row, bottom only
      send_request(ActCell, 8'd15, 8'd15);     // last row, top only
      send_request(ActCell, 8'd7, 8'd3);
      send_request(ActCell, 8'd16, 8'd0);      // cell out of range
      send_request(ActCell, 8'd255, 8'd255);
      drain_mesh();
   endtask

   // register extremes: zero (single) and 255 segments, zero and full radius, then three segments
   task automatic test_register_extremes();
      set_sphere(8'd0, 16'd0);
      send_request(ActVertex, 8'd0, 8'd0);
      send_request(ActVertex, 8'd1, 8'd1);
      send_request(ActVertex, 8'd2, 8'd0);
      send_request(ActCell, 8'd0, 8'd0);       // single cell gives nothing
      set_sphere(8'd255, 16'hFFFF);
      send_request(ActVertex, 8'd255, 8'd255);
      send_request(ActVertex, 8'd0, 8'd0);
      send_request(ActVertex, 8'd128, 8'd64);
      send_request(ActCell, 8'd254, 8'd254);   // widest indices
      send_request(ActCell, 8'd0, 8'd0);
      set_sphere(8'd3, 16'h8000);
      send_request(ActVertex, 8'd3, 8'd2);
      send_request(ActCell, 8'd1, 8'd2);
      send_request(ActCell, 8'd2, 8'd0);
      drain_mesh();
   endtask

   // random spheres with bursts of mostly in-range requests
   task automatic test_random_mesh();
      logic [7:0] seg;
      logic [15:0] rad;
      logic act;
      logic [7:0] row, col;
      int lim, burst;
      for (int ph = 0; ph < 10; ph++) begin
         case ($urandom_range(0, 5))
            0: seg = 8'd1;
            1: seg = 8'd2;
            2: seg = 8'd255;
            3, 4: seg = 8'($urandom_range(3, 24));
            default: seg = 8'($urandom_range(0, 255));
         endcase
         case ($urandom_range(0, 3))
            0: rad = 16'd0;
            1: rad = 16'hFFFF;
            default: rad = 16'($urandom_range(0, 65535));
         endcase
         set_sphere(seg, rad);
         for (int k = 0; k < 110; k++) begin
            act = 1'($urandom_range(0, 1));
            lim = int'((act == ActVertex) ? eff_segments() : eff_segments() - 1);
            if (lim < 0) lim = 0;
            if ($urandom_range(0, 99) < 85) begin
               row = 8'($urandom_range(0, lim));
               col = 8'($urandom_range(0, lim));
            end else begin
               row = 8'($urandom_range(0, 255));
               col = 8'($urandom_range(0, 255));
            end
            send_request(act, row, col);
            // bursts of random length, no gaps in the even phases' first half
            if (burst > 0) burst--;
            else begin
               burst = $urandom_range(1, 20);
               if (!(ph % 2 == 0 && k < 55)) pause_sender($urandom_range(1, 8));
            end
         end
      end
      drain_mesh();
   endtask

   task automatic check_field(input string name, input logic [16:0] exp_v,
                              input logic [16:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         errors++;
      end
   endtask

   // result checker, one strobe per result
   always @(posedge clock) begin
      mesh_rsp_type m;
      if (!reset && rsp_valid) begin
         if (mesh_queue.size() == 0) begin
            $error("result with no request pending");
            errors++;
         end else begin
            m = mesh_queue.pop_front();
            check_field("pos_x", 17'(m.pos_x), 17'(rsp_pos_x));
            check_field("pos_y", 17'(m.pos_y), 17'(rsp_pos_y));
            check_field("pos_z", 17'(m.pos_z), 17'(rsp_pos_z));
            check_field("norm_x", 17'(m.norm_x), 17'(rsp_norm_x));
            check_field("norm_y", 17'(m.norm_y), 17'(rsp_norm_y));
            check_field("norm_z", 17'(m.norm_z), 17'(rsp_norm_z));
            check_field("tex_s", m.tex_s, rsp_tex_s);
            check_field("tex_t", m.tex_t, rsp_tex_t);
            check_field("tri_a", 17'(m.tri_a), 17'(rsp_tri_a));
            check_field("tri_b", 17'(m.tri_b), 17'(rsp_tri_b));
            check_field("tri_c", 17'(m.tri_c), 17'(rsp_tri_c));
            check_field("last", 17'(m.last), 17'(rsp_last));
            if (rsp_tri_a == 16'd0 && rsp_tri_b == 16'd0 && rsp_tri_c == 16'd0)
               n_vertices++;
            else
               n_triangles++;
         end
      end
   end

   // watchdog on cycles with neither a request nor a result
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_action <= 1'b0;
      req_row <= 8'd0;
      req_col <= 8'd0;
      csr_we <= 1'b0;
      csr_index <= 1'b0;
      csr_wdata <= 16'd0;
      seg_shadow = 8'd16;
      radius_shadow = 16'd256;
      errors = 0;
      n_requests = 0;
      n_vertices = 0;
      n_triangles = 0;
      n_settings = 1;
      idle_cycles = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_grid();
      test_register_extremes();
      test_random_mesh();
      $display("covered %0d requests over %0d sphere settings", n_requests, n_settings);
      $display("checked %0d vertex and %0d triangle results", n_vertices, n_triangles);
      if (errors == 0 && mesh_queue.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
